@@ rtl/core/lzss_image_decompressor_macros.svh @@
// Assertion macros shared by the decompressor modules.
`ifndef LZSS_IMAGE_DECOMPRESSOR_MACROS_SVH
`define LZSS_IMAGE_DECOMPRESSOR_MACROS_SVH

`ifndef SYNTHESIS
`define LZD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LZD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define LZD_ASSERT(label, clk, rst, prop, msg)
`define LZD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

@@ rtl/core/lzd_pkg.sv @@
// Types and constants shared by the LZSS image decompressor modules.
package lzd_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic       KIND_DATA    = 1'b0;
   localparam logic       KIND_STATUS  = 1'b1;
   localparam logic [1:0] STATUS_GOOD  = 2'd0;
   localparam logic [1:0] STATUS_BAD   = 2'd1;
   localparam logic [1:0] STATUS_SHORT = 2'd2;

   localparam logic [31:0] HEADER_BYTES  = 32'd8;
   localparam logic [3:0]  FLAG_COUNT    = 4'd8;
   localparam logic [4:0]  MATCH_MIN_LEN = 5'd3;

   // One command per item that produces results.
   typedef struct packed {
      logic        wp_clear;   // first command of a new image
      logic        has_data;
      logic        is_match;
      logic [7:0]  data;       // literal byte
      logic [3:0]  len_code;   // match length minus three
      logic [11:0] ofs_code;   // match offset minus one
      logic        has_status;
      logic [1:0]  status;
   } lzd_cmd_type;

endpackage

@@ rtl/core/lzss_image_decompressor.sv @@
// LZSS image decompressor, top level.
// Input channel req_*: one image byte per item in req_tdata; req_tuser marks the
// first byte of an image (checksum word, size word, then flag groups).
// Result channel rsp_*: decoded bytes (rsp_tuser 0) and one closing status item
// (rsp_tuser 1) per image; rsp_tlast marks the last item caused by an input byte.
// The parser takes one item per cycle while the queue has room and places a
// command in a four-entry queue for each item that produces results.
// The copy engine takes a command from the queue in its idle state, then gives
// each literal or status item from its own state and each match byte through a
// read state and a copy state, since each match byte is a registered read from
// the history memory followed by its write back.
// The first result of an item passes the queue and the engine's command register
// to the output register; a match byte also passes the history read register.
// When the queue fills, req_tready drops until the engine catches up.
// A stalled receiver holds the output register and the engine waits with it.
// Reset empties the queue and returns both parts to idle; history contents are
// kept undefined until written and need no clearing pass.
module lzss_image_decompressor import lzd_pkg::*; #(
   parameter int HISTORY_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tuser,   // start_of_image
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], status[9:8], zero pad
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // run_last
);

   lzd_cmd_type push_cmd;
   lzd_cmd_type head_cmd;
   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;

   lzd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full_i   (q_full),
      .q_push_o   (q_push),
      .q_cmd_o    (push_cmd)
   );

   lzd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_i     (q_push),
      .push_cmd_i (push_cmd),
      .pop_i      (q_pop),
      .head_cmd_o (head_cmd),
      .full_o     (q_full),
      .empty_o    (q_empty)
   );

   lzd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty_i  (q_empty),
      .q_cmd_i    (head_cmd),
      .q_pop_o    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/core/lzd_cmd_queue.sv @@
// Short command queue between the parser and the copy engine.
`include "lzss_image_decompressor_macros.svh"

module lzd_cmd_queue import lzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_i,
   input  lzd_cmd_type push_cmd_i,
   input  logic        pop_i,
   output lzd_cmd_type head_cmd_o,
   output logic        full_o,
   output logic        empty_o
);

   lzd_cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign full_o     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty_o    = (count_ff == '0);
   assign head_cmd_o = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop_i) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop_i && !push_i) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= push_cmd_i;
      end
   end

   `LZD_ASSERT(a_push_room, clock, reset, push_i |-> !full_o, "push into a full queue")
   `LZD_ASSERT(a_pop_data, clock, reset, pop_i |-> !empty_o, "pop from an empty queue")
   `LZD_ASSERT(a_push_fills, clock, reset, (push_i && !pop_i) |=> !empty_o,
      "queue empty after a push")

endmodule

@@ rtl/core/lzd_front.sv @@
// Parser: header, checksum, flag bits, tokens; one item per cycle unless q_full_i.
module lzd_front import lzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        q_full_i,
   output logic        q_push_o,
   output lzd_cmd_type q_cmd_o
);

   logic [31:0] idx_ff, idx_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] sum_ff, sum_in;
   logic [7:0]  flags_ff, flags_in;
   logic [3:0]  bits_left_ff, bits_left_in;
   logic        await_ff, await_in;
   logic [7:0]  tok_hi_ff, tok_hi_in;
   logic        active_ff, active_in;
   logic        clear_pend_ff, clear_pend_in;

   logic        fire;
   logic [7:0]  b;
   logic [31:0] idx_e, size_e, sum_e;
   logic [7:0]  flags_e, tok_hi_e;
   logic [3:0]  bits_left_e;
   logic        await_e, active_e, clear_e;
   lzd_cmd_type cmd;

   assign req_tready = !q_full_i;
   assign fire       = req_tvalid && req_tready;
   assign b          = req_tdata;

   always_comb begin
      // A start item restarts the parser before the byte is looked at.
      idx_e       = req_tuser ? '0 : idx_ff;
      size_e      = req_tuser ? '0 : size_ff;
      sum_e       = req_tuser ? '0 : sum_ff;
      flags_e     = req_tuser ? '0 : flags_ff;
      bits_left_e = req_tuser ? '0 : bits_left_ff;
      await_e     = req_tuser ? 1'b0 : await_ff;
      tok_hi_e    = req_tuser ? '0 : tok_hi_ff;
      active_e    = req_tuser || active_ff;
      clear_e     = req_tuser || clear_pend_ff;

      idx_in       = idx_e;
      size_in      = size_e;
      sum_in       = sum_e;
      flags_in     = flags_e;
      bits_left_in = bits_left_e;
      await_in     = await_e;
      tok_hi_in    = tok_hi_e;
      active_in    = active_e;

      cmd          = '0;
      cmd.wp_clear = clear_e;
      cmd.data     = b;
      cmd.len_code = tok_hi_e[7:4];
      cmd.ofs_code = {tok_hi_e[3:0], b};

      if (active_e) begin
         if (idx_e[31:2] == '0) begin
            sum_in = {sum_e[23:0], b};
         end else if (idx_e[31:3] == '0) begin
            size_in = {size_e[23:0], b};
            sum_in  = sum_e + 32'(b);
         end else begin
            sum_in = sum_e + 32'(b);
            if (await_e) begin
               await_in     = 1'b0;
               cmd.has_data = 1'b1;
               cmd.is_match = 1'b1;
            end else if (bits_left_e == '0) begin
               flags_in     = b;
               bits_left_in = FLAG_COUNT;
            end else begin
               flags_in     = {flags_e[6:0], 1'b0};
               bits_left_in = bits_left_e - 4'd1;
               if (flags_e[7]) begin
                  tok_hi_in = b;
                  await_in  = 1'b1;
               end else begin
                  cmd.has_data = 1'b1;
               end
            end
         end

         if (idx_e == 32'd7 && size_in < HEADER_BYTES) begin
            cmd.has_status = 1'b1;
            cmd.status     = STATUS_SHORT;
            active_in      = 1'b0;
         end else if ((idx_e[31:3] != '0 || idx_e[2:0] == 3'd7) &&
                      idx_e == size_in - 32'd1) begin
            // A match token cut off by the end of the image is dropped.
            await_in       = 1'b0;
            cmd.has_status = 1'b1;
            cmd.status     = (sum_in == '0) ? STATUS_GOOD : STATUS_BAD;
            active_in      = 1'b0;
         end
         idx_in = idx_e + 32'd1;
      end
   end

   assign q_push_o = fire && (cmd.has_data || cmd.has_status);
   assign q_cmd_o  = cmd;

   always_comb begin
      clear_pend_in = clear_pend_ff;
      if (fire) begin
         clear_pend_in = q_push_o ? 1'b0 : clear_e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         size_ff       <= '0;
         sum_ff        <= '0;
         flags_ff      <= '0;
         bits_left_ff  <= '0;
         await_ff      <= 1'b0;
         tok_hi_ff     <= '0;
         active_ff     <= 1'b0;
         clear_pend_ff <= 1'b0;
      end else begin
         clear_pend_ff <= clear_pend_in;
         if (fire) begin
            idx_ff       <= idx_in;
            size_ff      <= size_in;
            sum_ff       <= sum_in;
            flags_ff     <= flags_in;
            bits_left_ff <= bits_left_in;
            await_ff     <= await_in;
            tok_hi_ff    <= tok_hi_in;
            active_ff    <= active_in;
         end
      end
   end

endmodule

@@ rtl/core/lzd_back.sv @@
// Copy engine: history memory, literal and match output, and the status item.
`include "lzss_image_decompressor_macros.svh"

module lzd_back import lzd_pkg::*; #(
   parameter int HISTORY_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty_i,
   input  lzd_cmd_type q_cmd_i,
   output logic        q_pop_o,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // out_byte[7:0], status[9:8], zero pad
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast   // run_last
);

   localparam int PTR_W = $clog2(HISTORY_DEPTH);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LIT  = 5'b00010,
      S_READ = 5'b00100,
      S_COPY = 5'b01000,
      S_STAT = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   lzd_cmd_type       cmd_ff, cmd_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   logic [7:0]        hist_mem [HISTORY_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [PTR_W-1:0]  rd_addr;
   logic              rd_en;
   logic              wr_en;
   logic [7:0]        wr_data;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rd_addr  = wp_ff - PTR_W'(cmd_ff.ofs_code) - PTR_W'(1);
   assign rd_en    = (state_ff == S_READ);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      cnt_in        = cnt_ff;
      wp_in         = wp_ff;
      q_pop_o       = 1'b0;
      wr_en         = 1'b0;
      wr_data       = cmd_ff.data;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty_i) begin
               q_pop_o = 1'b1;
               cmd_in  = q_cmd_i;
               cnt_in  = 5'(q_cmd_i.len_code) + MATCH_MIN_LEN;
               if (q_cmd_i.wp_clear) begin
                  wp_in = '0;
               end
               if (q_cmd_i.has_data && q_cmd_i.is_match) begin
                  state_in = S_READ;
               end else if (q_cmd_i.has_data) begin
                  state_in = S_LIT;
               end else begin
                  state_in = S_STAT;
               end
            end
         end
         S_LIT: begin
            if (out_free) begin
               wr_en         = 1'b1;
               wp_in         = wp_ff + PTR_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_DATA;
               rsp_byte_in   = cmd_ff.data;
               rsp_last_in   = !cmd_ff.has_status;
               rsp_status_in = STATUS_GOOD;
               state_in      = cmd_ff.has_status ? S_STAT : S_IDLE;
            end
         end
         S_READ: begin
            state_in = S_COPY;
         end
         S_COPY: begin
            if (out_free) begin
               wr_en         = 1'b1;
               wr_data       = rd_data_ff;
               wp_in         = wp_ff + PTR_W'(1);
               cnt_in        = cnt_ff - 5'd1;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_DATA;
               rsp_byte_in   = rd_data_ff;
               rsp_status_in = STATUS_GOOD;
               if (cnt_ff == 5'd1) begin
                  rsp_last_in = !cmd_ff.has_status;
                  state_in    = cmd_ff.has_status ? S_STAT : S_IDLE;
               end else begin
                  rsp_last_in = 1'b0;
                  state_in    = S_READ;
               end
            end
         end
         S_STAT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_STATUS;
               rsp_byte_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = cmd_ff.status;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cnt_ff        <= cnt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wp_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `LZD_ASSERT(a_copy_count, clock, reset, (state_ff == S_COPY) |-> (cnt_ff != 5'd0),
      "match copy with no bytes left")
   `LZD_ASSERT(a_read_to_copy, clock, reset, (state_ff == S_READ) |=> (state_ff == S_COPY),
      "history read not followed by its copy")
   `LZD_ASSERT_NEVER(a_status_form, clock, reset,
      rsp_valid_ff && rsp_kind_ff && (rsp_byte_ff != 8'd0 || !rsp_last_ff),
      "status item with data or without last")

endmodule

@@ sim/lzss_image_checker.sv @@
// Watches both streams of the decompressor, predicts every result item and compares it.
module lzss_image_checker import lzd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tuser,   // start_of_image
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // out_byte[7:0], status[9:8], zero pad
   input  logic        rsp_tuser,   // kind
   input  logic        rsp_tlast,   // run_last
   output int          mismatch_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;
   localparam int HIST_DEPTH  = 4096;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       run_last;
      logic [1:0] status;
      logic [5:0] pad;
   } decoded_item_type;

   decoded_item_type expected_q[$];
   decoded_item_type step_q[$];

   logic [7:0]  history_mem [HIST_DEPTH];
   logic [11:0] wr_ptr;
   logic [31:0] byte_count;
   logic [31:0] size_word;
   logic [31:0] checksum_acc;
   logic [7:0]  flag_reg;
   logic [3:0]  flags_left;
   logic        second_pending;
   logic [7:0]  token_first;
   logic        in_image;
   int          errors = 0;

   function automatic void clear_parser();
      wr_ptr         = 12'd0;
      byte_count     = 32'd0;
      size_word      = 32'd0;
      checksum_acc   = 32'd0;
      flag_reg       = 8'd0;
      flags_left     = 4'd0;
      second_pending = 1'b0;
      token_first    = 8'd0;
      in_image       = 1'b0;
   endfunction

   function automatic void push_result(logic kind, logic [7:0] value, logic [1:0] st);
      step_q.push_back('{kind: kind, out_byte: value, run_last: 1'b0, status: st,
                         pad: 6'd0});
   endfunction

   function automatic void emit_byte(logic [7:0] value);
      history_mem[wr_ptr] = value;
      wr_ptr = wr_ptr + 12'd1;
      push_result(KIND_DATA, value, STATUS_GOOD);
   endfunction

   // Flag groups: a flag byte, then one literal or one two-byte token per flag bit.
   function automatic void decode_body_byte(logic [7:0] b);
      logic [4:0]  copy_len;
      logic [12:0] distance;
      logic [11:0] src;
      int          k;
      if (second_pending) begin
         second_pending = 1'b0;
         copy_len = {1'b0, token_first[7:4]} + MATCH_MIN_LEN;
         distance = {1'b0, token_first[3:0], b} + 13'd1;
         for (k = 0; k < copy_len; k++) begin
            // The source advances with the write pointer, so short distances repeat.
            src = wr_ptr - distance[11:0];
            emit_byte(history_mem[src]);
         end
      end else if (flags_left == 4'd0) begin
         flag_reg   = b;
         flags_left = FLAG_COUNT;
      end else begin
         flags_left = flags_left - 4'd1;
         if (flag_reg[7]) begin
            token_first    = b;
            second_pending = 1'b1;
         end else begin
            emit_byte(b);
         end
         flag_reg = flag_reg << 1;
      end
   endfunction

   function automatic void predict_item(logic [7:0] b, logic first);
      if (first) begin
         clear_parser();
         in_image = 1'b1;
      end
      step_q.delete();
      if (in_image) begin
         if (byte_count < 32'd4) begin
            checksum_acc = {checksum_acc[23:0], b};
         end else if (byte_count < HEADER_BYTES) begin
            size_word    = {size_word[23:0], b};
            checksum_acc = checksum_acc + {24'd0, b};
         end else begin
            checksum_acc = checksum_acc + {24'd0, b};
            decode_body_byte(b);
         end
         if (byte_count == HEADER_BYTES - 32'd1 && size_word < HEADER_BYTES) begin
            push_result(KIND_STATUS, 8'h00, STATUS_SHORT);
            in_image = 1'b0;
         end else if (byte_count >= HEADER_BYTES - 32'd1 &&
                      byte_count == size_word - 32'd1) begin
            // A token whose second byte lies past the end is dropped.
            second_pending = 1'b0;
            push_result(KIND_STATUS, 8'h00,
                        (checksum_acc == 32'd0) ? STATUS_GOOD : STATUS_BAD);
            in_image = 1'b0;
         end
         byte_count = byte_count + 32'd1;
         if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
         foreach (step_q[i]) expected_q.push_back(step_q[i]);
      end
   endfunction

   always @(posedge clock) begin
      decoded_item_type got;
      decoded_item_type want;
      if (reset) begin
         clear_parser();
         expected_q.delete();
      end else begin
         if (req_tvalid && req_tready) predict_item(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            got = '{kind: rsp_tuser, out_byte: rsp_tdata[7:0], run_last: rsp_tlast,
                    status: rsp_tdata[9:8], pad: rsp_tdata[15:10]};
            if (expected_q.size() == 0) begin
               if (errors < MAX_REPORTS)
                  $display("%0t: unexpected item kind %0d byte %02h last %0d status %0d",
                           $time, got.kind, got.out_byte, got.run_last, got.status);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  if (errors < MAX_REPORTS)
                     $display({"%0t: mismatch, expected kind %0d byte %02h last %0d ",
                               "status %0d pad %02h, got kind %0d byte %02h last %0d ",
                               "status %0d pad %02h"}, $time,
                              want.kind, want.out_byte, want.run_last, want.status,
                              want.pad, got.kind, got.out_byte, got.run_last,
                              got.status, got.pad);
                  errors++;
               end
            end
         end
      end
      pending_results <= expected_q.size();
      mismatch_count  <= errors;
   end

endmodule

@@ sim/tb_lzss_image_decompressor.sv @@
// Stimulus and verdict for the LZSS image decompressor, checked by lzss_image_checker.
module tb_lzss_image_decompressor import lzd_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 185;
   // History entries written by the fixed match image early in the run.
   localparam int EARLY_WRITTEN  = 20;

   typedef enum int {SUM_GOOD, SUM_BAD, SUM_ANY} checksum_choice_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          mismatch_count;
   int          pending_results;

   logic [7:0] body_q[$];
   logic [7:0] image_q[$];
   int         decoded_len;
   int         send_calm;
   int         parsed_items;
   int         idle_cycles = 0;

   lzss_image_decompressor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   lzss_image_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: a random stall before each item, with occasional runs of no stalls.
   initial begin
      int stall;
      int calm;
      calm = 0;
      forever begin
         if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            stall = $urandom_range(0, 15);
            if ($urandom_range(0, 31) == 0) calm = $urandom_range(16, 64);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   task automatic send_item(input logic [7:0] value, input logic first);
      int gap;
      if (send_calm > 0) begin
         gap = 0;
         send_calm--;
      end else begin
         gap = $urandom_range(0, 15);
         if ($urandom_range(0, 31) == 0) send_calm = $urandom_range(16, 64);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= first;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // Builds flag groups up to body_len bytes. A match reaches either back into
   // the bytes of this image or forward into the entries left by the early match
   // image, so it never reads an entry that has not been written since reset.
   task automatic build_body(input int body_len);
      logic [7:0]  group_q[$];
      logic [7:0]  flags;
      logic [3:0]  len_code;
      logic [11:0] ofs_code;
      int          reach;
      int          slot;
      int          src;
      body_q.delete();
      decoded_len = 0;
      while (body_q.size() < body_len) begin
         group_q.delete();
         flags = 8'h00;
         for (slot = 7; slot >= 0; slot--) begin
            reach    = decoded_len;
            len_code = 4'($urandom_range(0, 15));
            if (decoded_len + len_code + 3 <= EARLY_WRITTEN &&
                $urandom_range(0, 3) == 0) begin
               // The source lies at or past the write pointer, in an older image.
               src = $urandom_range(decoded_len, EARLY_WRITTEN - len_code - 3);
               ofs_code = 12'(4095 + decoded_len - src);
               flags[slot] = 1'b1;
               group_q.push_back({len_code, ofs_code[11:8]});
               group_q.push_back(ofs_code[7:0]);
               decoded_len += len_code + 3;
            end else if (reach > 0 && $urandom_range(0, 2) == 0) begin
               flags[slot] = 1'b1;
               if ($urandom_range(0, 3) == 0) ofs_code = 12'(reach - 1);
               else ofs_code = 12'($urandom_range(0, reach - 1));
               group_q.push_back({len_code, ofs_code[11:8]});
               group_q.push_back(ofs_code[7:0]);
               decoded_len += len_code + 3;
            end else begin
               group_q.push_back(8'($urandom));
               decoded_len++;
            end
         end
         body_q.push_back(flags);
         foreach (group_q[i]) body_q.push_back(group_q[i]);
      end
      while (body_q.size() > body_len) void'(body_q.pop_back());
   endtask

   // Prepends the checksum and size words to the current body.
   task automatic make_image(input logic [31:0] size_word,
                             input checksum_choice_type choice);
      logic [31:0] sum;
      logic [31:0] check;
      logic [31:0] delta;
      int          k;
      sum = size_word[31:24] + size_word[23:16] + size_word[15:8] + size_word[7:0];
      foreach (body_q[i]) sum += body_q[i];
      delta = $urandom;
      if (delta == 32'd0) delta = 32'd1;
      case (choice)
         SUM_GOOD: check = -sum;
         SUM_BAD:  check = -sum + delta;
         default:  check = $urandom;
      endcase
      image_q.delete();
      for (k = 3; k >= 0; k--) image_q.push_back(check[k*8 +: 8]);
      for (k = 3; k >= 0; k--) image_q.push_back(size_word[k*8 +: 8]);
      foreach (body_q[i]) image_q.push_back(body_q[i]);
   endtask

   task automatic send_image(input int count);
      int k;
      for (k = 0; k < count; k++) send_item(image_q[k], k == 0);
      parsed_items += count;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending_results != 0);
   endtask

   initial begin
      int          shape;
      int          n;
      int          start_items;
      bit          open_image;
      logic [31:0] size_word;
      req_tvalid   <= 1'b0;
      req_tdata    <= 8'h00;
      req_tuser    <= 1'b0;
      reset        <= 1'b1;
      send_calm    = 0;
      parsed_items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A byte with no image started is ignored.
      send_item(8'hFF, 1'b0);
      // An image cut short by the start of the next one sends nothing.
      body_q.delete();
      make_image(32'hFFFF_FFFF, SUM_ANY);
      send_image(2);
      // Size word below the header length.
      make_image(32'd7, SUM_ANY);
      send_image(8);
      // Two literals, then a longest match on the last byte: 18 bytes and the status.
      body_q = '{8'h20, 8'h00, 8'hFF, 8'hF0, 8'h01};
      make_image(32'd13, SUM_GOOD);
      send_image(13);
      req_tvalid <= 1'b0;
      wait_drained();

      n = 0;
      open_image = 1'b0;
      start_items = parsed_items;
      while (parsed_items - start_items < RANDOM_ITEMS) begin
         // The first two images are a header-only one and a cut-off match.
         shape = (n < 2) ? 11 + n : $urandom_range(0, 15);
         n++;
         if (shape <= 9) begin
            build_body($urandom_range(1, 30));
            make_image(HEADER_BYTES + 32'(body_q.size()),
                       ($urandom_range(0, 3) == 0) ? SUM_BAD : SUM_GOOD);
            send_image(image_q.size());
            open_image = 1'b0;
         end else if (shape == 10) begin
            body_q.delete();
            make_image(32'($urandom_range(0, 7)), SUM_ANY);
            send_image(8);
            open_image = 1'b0;
         end else if (shape == 11) begin
            body_q.delete();
            make_image(HEADER_BYTES, ($urandom_range(0, 1) == 0) ? SUM_BAD : SUM_GOOD);
            send_image(8);
            open_image = 1'b0;
         end else if (shape == 12) begin
            body_q = '{8'h80 | 8'($urandom_range(0, 127)), 8'($urandom)};
            make_image(HEADER_BYTES + 32'd2,
                       ($urandom_range(0, 1) == 0) ? SUM_BAD : SUM_GOOD);
            send_image(10);
            open_image = 1'b0;
         end else if (shape <= 14) begin
            // Abandoned image: the size word lies far past the bytes that are sent.
            build_body($urandom_range(1, 30));
            size_word = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)};
            make_image(size_word, SUM_ANY);
            send_image($urandom_range(1, image_q.size()));
            open_image = 1'b1;
         end else if (!open_image) begin
            repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ lzss_image_decompressor.f @@
+incdir+rtl/core
rtl/core/lzd_pkg.sv
rtl/core/lzd_cmd_queue.sv
rtl/core/lzd_front.sv
rtl/core/lzd_back.sv
rtl/core/lzss_image_decompressor.sv
sim/lzss_image_checker.sv
sim/tb_lzss_image_decompressor.sv
